[src/gda_pkg.sv]
// Shared types and codes for the Gregorian date arithmetic block.
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 21;
  localparam int DIFF_W  = 23;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_CMP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ORDER_EARLIER = 2'd0,
    ORDER_EQUAL   = 2'd1,
    ORDER_LATER   = 2'd2
  } order_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CHK,
    S_SER_INIT,
    S_SER_MON,
    S_RANGE,
    S_EST,
    S_FY_DOWN,
    S_FY_UP,
    S_FY_REM,
    S_FY_MON,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    YOP_KEEP,
    YOP_IN,
    YOP_CUR,
    YOP_EST,
    YOP_DEC,
    YOP_INC
  } yop_sel_t;

  typedef enum logic [2:0] {
    SER_KEEP,
    SER_INIT,
    SER_ADD_MONTH,
    SER_SHIFT,
    SER_SUB_YS,
    SER_SUB_MONTH
  } ser_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_INVALID,
    RES_RANGE,
    RES_CMP
  } res_t;

  typedef struct packed {
    logic     capture;
    yop_sel_t yop_sel;
    logic     src_in;
    ser_op_t  ser_op;
    logic     k_clr;
    logic     k_inc;
    logic     save_given;
    logic     est_load;
    logic     load_in_date;
    logic     load_new_date;
    res_t     res;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  ys_ready;
    logic  in_valid;
    logic  k_lt_m;
    logic  ser_neg;
    logic  ser_over;
    logic  ys_gt_ser;
    logic  yop_gt1;
    logic  mon_fits;
  } sts_t;

endpackage

[src/gda_if.sv]
// Request and response channel interfaces of the date arithmetic block.
interface gda_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [13:0]        year_in;
  logic [3:0]         month_in;
  logic [4:0]         day_in;
  logic signed [20:0] day_count;

  modport source (output valid, mode, year_in, month_in, day_in, day_count, input ready);
  modport sink (input valid, mode, year_in, month_in, day_in, day_count, output ready);
endinterface

interface gda_rsp_if;
  logic               valid;
  logic               ready;
  logic [13:0]        cur_year_out;
  logic [3:0]         cur_month_out;
  logic [4:0]         cur_day_out;
  logic [1:0]         order;
  logic signed [22:0] difference;
  logic [1:0]         status;

  modport source (output valid, cur_year_out, cur_month_out, cur_day_out, order, difference,
                  status, input ready);
  modport sink (input valid, cur_year_out, cur_month_out, cur_day_out, order, difference,
                status, output ready);
endinterface

[src/gda_dpath.sv]
// Datapath: date registers, year-start unit, serial accumulator and result registers.
module gda_dpath #(
  parameter int MAX_YEAR = 9999
) (
  input  logic               clk,
  input  logic               rst,
  input  gda_pkg::cmd_t      cmd,
  output gda_pkg::sts_t      sts,
  input  logic [1:0]         mode,
  input  logic [13:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [20:0] day_count,
  output logic [13:0]        cur_year_out,
  output logic [3:0]         cur_month_out,
  output logic [4:0]         cur_day_out,
  output logic [1:0]         order,
  output logic signed [22:0] difference,
  output logic [1:0]         status
);
  import gda_pkg::*;

  localparam int SER_W = 24;
  localparam int YS_W  = 22;
  localparam logic signed [SER_W-1:0] SER_LIMIT =
    SER_W'(365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);
  localparam logic [24:0] DIV25_MUL = 25'd5243;
  localparam logic [35:0] EST_MUL   = 36'd11484;

  // x/100 for 14-bit x: (x/4)/25 by reciprocal, exact for this range
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [24:0] prod;
    prod = {13'b0, x[13:2]} * DIV25_MUL;
    return prod[24:17];
  endfunction

  function automatic logic [4:0] month_days(input logic lp, input logic [3:0] mo);
    case (mo)
      4'd2: return lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  mode_t                    in_mode;
  logic [YEAR_W-1:0]        in_year;
  logic [MONTH_W-1:0]       in_month;
  logic [DAY_W-1:0]         in_day;
  logic signed [COUNT_W-1:0] in_count;

  logic [YEAR_W-1:0]  cur_year;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;

  logic [YEAR_W-1:0] yop;
  logic [YEAR_W-1:0] yop_next;
  logic [1:0]        ys_wait;

  logic [YEAR_W-1:0] a_y;
  logic [YS_W-1:0]   a_m365;
  logic [7:0]        a_q100p;
  logic [7:0]        a_q100y;
  logic [YS_W-1:0]   ys;
  logic              leap;

  logic signed [SER_W-1:0] ser;
  logic signed [SER_W-1:0] ser_next;
  logic signed [SER_W-1:0] ser_given;
  logic [MONTH_W-1:0]      k;
  logic [YEAR_W-1:0]       est_year;

  logic [1:0]         order_r;
  logic signed [22:0] diff_r;
  logic [1:0]         status_r;

  logic [YEAR_W-1:0]       p_a;
  logic [YEAR_W-1:0]       p_b;
  logic [YEAR_W-1:0]       m100;
  logic                    is100;
  logic [MONTH_W-1:0]      src_month;
  logic [DAY_W-1:0]        src_day;
  logic [4:0]              dim_k;
  logic signed [SER_W-1:0] ys_ext;
  logic signed [SER_W-1:0] dim_ext;
  logic signed [SER_W-1:0] day_ext;
  logic signed [SER_W-1:0] cnt_ext;
  logic signed [SER_W-1:0] diff_full;
  logic [35:0]             est_prod;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode  <= mode_t'(mode);
      in_year  <= year_in;
      in_month <= month_in;
      in_day   <= day_in;
      in_count <= day_count;
    end
  end

  // year-start and leap unit: two register stages behind yop
  assign p_a  = yop - 14'd1;
  assign p_b  = a_y - 14'd1;
  assign m100 = 14'(a_q100y) * 14'd100;
  assign is100 = (m100 == a_y);

  always_ff @(posedge clk) begin
    a_y     <= yop;
    a_m365  <= 22'(p_a) * 22'd365;
    a_q100p <= div100(p_a);
    a_q100y <= div100(yop);
    ys      <= a_m365 + 22'(p_b[13:2]) - 22'(a_q100p) + 22'(a_q100p[7:2]);
    leap    <= (a_y[1:0] == 2'b00) && (!is100 || (a_q100y[1:0] == 2'b00));
  end

  always_comb begin
    case (cmd.yop_sel)
      YOP_IN:  yop_next = in_year;
      YOP_CUR: yop_next = cur_year;
      YOP_EST: yop_next = est_year + 14'd1;
      YOP_DEC: yop_next = yop - 14'd1;
      YOP_INC: yop_next = yop + 14'd1;
      default: yop_next = yop;
    endcase
  end

  always_ff @(posedge clk) begin
    yop <= yop_next;
    if (rst) begin
      ys_wait <= 2'd0;
    end else if (cmd.yop_sel != YOP_KEEP) begin
      ys_wait <= 2'd2;
    end else if (ys_wait != 2'd0) begin
      ys_wait <= ys_wait - 2'd1;
    end
  end

  // serial accumulator
  assign src_month = cmd.src_in ? in_month : cur_month;
  assign src_day   = cmd.src_in ? in_day : cur_day;
  assign dim_k     = month_days(leap, k);
  assign ys_ext    = {2'b00, ys};
  assign dim_ext   = {19'b0, dim_k};
  assign day_ext   = {19'b0, src_day};
  assign cnt_ext   = {{(SER_W - COUNT_W){in_count[COUNT_W-1]}}, in_count};
  assign diff_full = ser - ser_given;
  assign est_prod  = {14'b0, ser[21:0]} * EST_MUL;

  always_comb begin
    case (cmd.ser_op)
      SER_INIT:      ser_next = ys_ext + day_ext - 24'sd1;
      SER_ADD_MONTH: ser_next = ser + dim_ext;
      SER_SHIFT:     ser_next = (in_mode == MODE_ADD) ? ser + cnt_ext : ser - cnt_ext;
      SER_SUB_YS:    ser_next = ser - ys_ext;
      SER_SUB_MONTH: ser_next = ser - dim_ext;
      default:       ser_next = ser;
    endcase
  end

  always_ff @(posedge clk) begin
    ser <= ser_next;
    if (cmd.save_given) begin
      ser_given <= ser;
    end
    if (cmd.est_load) begin
      est_year <= est_prod[35:22];
    end
    if (cmd.k_clr) begin
      k <= 4'd1;
    end else if (cmd.k_inc) begin
      k <= k + 4'd1;
    end
  end

  // current date
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= 14'd2019;
      cur_month <= 4'd1;
      cur_day   <= 5'd1;
    end else if (cmd.load_in_date) begin
      cur_year  <= in_year;
      cur_month <= in_month;
      cur_day   <= in_day;
    end else if (cmd.load_new_date) begin
      cur_year  <= yop;
      cur_month <= k;
      cur_day   <= ser[4:0] + 5'd1;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_OK: begin
        order_r  <= ORDER_EARLIER;
        diff_r   <= '0;
        status_r <= STATUS_OK;
      end
      RES_INVALID: begin
        order_r  <= ORDER_EARLIER;
        diff_r   <= '0;
        status_r <= STATUS_INVALID;
      end
      RES_RANGE: begin
        order_r  <= ORDER_EARLIER;
        diff_r   <= '0;
        status_r <= STATUS_RANGE;
      end
      RES_CMP: begin
        diff_r   <= diff_full[DIFF_W-1:0];
        status_r <= STATUS_OK;
        if (diff_full[SER_W-1]) begin
          order_r <= ORDER_EARLIER;
        end else if (diff_full == '0) begin
          order_r <= ORDER_EQUAL;
        end else begin
          order_r <= ORDER_LATER;
        end
      end
      default: begin
      end
    endcase
  end

  assign cur_year_out  = cur_year;
  assign cur_month_out = cur_month;
  assign cur_day_out   = cur_day;
  assign order         = order_r;
  assign difference    = diff_r;
  assign status        = status_r;

  always_comb begin
    sts.mode      = in_mode;
    sts.ys_ready  = (ys_wait == 2'd0);
    sts.in_valid  = (in_year >= 14'd1) && (in_year <= 14'(MAX_YEAR)) &&
                    (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day >= 5'd1) &&
                    (in_day <= month_days(leap, in_month));
    sts.k_lt_m    = (k < src_month);
    sts.ser_neg   = ser[SER_W-1];
    sts.ser_over  = (ser >= SER_LIMIT);
    sts.ys_gt_ser = (ys_ext > ser);
    sts.yop_gt1   = (yop > 14'd1);
    sts.mon_fits  = (k < 4'd12) && (ser >= dim_ext);
  end

  a_date_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !cmd.load_in_date && !cmd.load_new_date
      |=> $stable(cur_year) && $stable(cur_month) && $stable(cur_day))
    else $error("current date changed without a load command");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (cur_month >= 4'd1) && (cur_month <= 4'd12) && (cur_day >= 5'd1))
    else $error("current date holds an impossible month or day");

  a_day_offset: assert property (@(posedge clk) disable iff (rst)
    cmd.load_new_date |-> !ser[SER_W-1] && (ser < 24'sd31))
    else $error("day offset out of range when writing a new date");

endmodule

[src/gda_ctrl.sv]
// Controller: sequences date validation, serial conversion and year/month walks.
module gda_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  gda_pkg::sts_t sts,
  output gda_pkg::cmd_t cmd
);
  import gda_pkg::*;

  state_t state;
  state_t state_next;
  logic   phase_cur;
  logic   phase_cur_next;
  logic   is_cmp;
  logic   uses_in;

  assign is_cmp  = (sts.mode == MODE_CMP);
  assign uses_in = (sts.mode == MODE_LOAD) || is_cmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase_cur <= 1'b0;
    end else begin
      state     <= state_next;
      phase_cur <= phase_cur_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_START;
        end
      end
      S_START: state_next = uses_in ? S_CHK : S_SER_INIT;
      S_CHK: begin
        if (sts.ys_ready) begin
          if (!sts.in_valid || (sts.mode == MODE_LOAD)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SER_INIT;
          end
        end
      end
      S_SER_INIT: begin
        if (sts.ys_ready) begin
          state_next = S_SER_MON;
        end
      end
      S_SER_MON: begin
        if (!sts.k_lt_m) begin
          if (is_cmp && !phase_cur) begin
            state_next = S_SER_INIT;
          end else if (is_cmp) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RANGE;
          end
        end
      end
      S_RANGE: state_next = (sts.ser_neg || sts.ser_over) ? S_DONE : S_EST;
      S_EST: state_next = S_FY_DOWN;
      S_FY_DOWN: begin
        if (sts.ys_ready && !(sts.yop_gt1 && sts.ys_gt_ser)) begin
          state_next = S_FY_UP;
        end
      end
      S_FY_UP: begin
        if (sts.ys_ready && sts.ys_gt_ser) begin
          state_next = S_FY_REM;
        end
      end
      S_FY_REM: begin
        if (sts.ys_ready) begin
          state_next = S_FY_MON;
        end
      end
      S_FY_MON: begin
        if (!sts.mon_fits) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.yop_sel    = YOP_KEEP;
    cmd.ser_op     = SER_KEEP;
    cmd.res        = RES_NONE;
    cmd.src_in     = is_cmp && !phase_cur;
    phase_cur_next = phase_cur;
    req_ready      = 1'b0;
    rsp_valid      = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture    = 1'b1;
          phase_cur_next = 1'b0;
        end
      end
      S_START: cmd.yop_sel = uses_in ? YOP_IN : YOP_CUR;
      S_CHK: begin
        if (sts.ys_ready) begin
          if (!sts.in_valid) begin
            cmd.res = RES_INVALID;
          end else if (sts.mode == MODE_LOAD) begin
            cmd.load_in_date = 1'b1;
            cmd.res          = RES_OK;
          end
        end
      end
      S_SER_INIT: begin
        if (sts.ys_ready) begin
          cmd.ser_op = SER_INIT;
          cmd.k_clr  = 1'b1;
        end
      end
      S_SER_MON: begin
        if (sts.k_lt_m) begin
          cmd.ser_op = SER_ADD_MONTH;
          cmd.k_inc  = 1'b1;
        end else if (is_cmp && !phase_cur) begin
          // given date done; now convert the current date
          cmd.save_given = 1'b1;
          cmd.yop_sel    = YOP_CUR;
          phase_cur_next = 1'b1;
        end else if (is_cmp) begin
          cmd.res = RES_CMP;
        end else begin
          cmd.ser_op = SER_SHIFT;
        end
      end
      S_RANGE: begin
        if (sts.ser_neg || sts.ser_over) begin
          cmd.res = RES_RANGE;
        end else begin
          cmd.est_load = 1'b1;
        end
      end
      S_EST: cmd.yop_sel = YOP_EST;
      S_FY_DOWN: begin
        if (sts.ys_ready) begin
          cmd.yop_sel = (sts.yop_gt1 && sts.ys_gt_ser) ? YOP_DEC : YOP_INC;
        end
      end
      S_FY_UP: begin
        // probing year+1; back off one once its start passes the serial
        if (sts.ys_ready) begin
          cmd.yop_sel = sts.ys_gt_ser ? YOP_DEC : YOP_INC;
        end
      end
      S_FY_REM: begin
        if (sts.ys_ready) begin
          cmd.ser_op = SER_SUB_YS;
          cmd.k_clr  = 1'b1;
        end
      end
      S_FY_MON: begin
        if (sts.mon_fits) begin
          cmd.ser_op = SER_SUB_MONTH;
          cmd.k_inc  = 1'b1;
        end else begin
          cmd.load_new_date = 1'b1;
          cmd.res           = RES_OK;
        end
      end
      S_DONE: rsp_valid = 1'b1;
      default: begin
      end
    endcase
  end

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second word taken while one is in progress");

  a_phase_mode: assert property (@(posedge clk) disable iff (rst)
    phase_cur |-> is_cmp)
    else $error("compare phase set outside compare mode");

  a_return_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && rsp_ready |=> req_ready)
    else $error("block not ready after result taken");

endmodule

[src/gregorian_date_arithmetic.sv]
// One word is in progress at a time; the next is taken once the result has been read.
// The time a word takes is set by the shared two-stage year-start unit
// and the month walks (one month per cycle) for date-to-serial and serial-to-date.
// Reset: current date 2019-01-01, controller idle and ready.
module gregorian_date_arithmetic #(
  parameter int MAX_YEAR = 9999
) (
  input logic clk,
  input logic rst,
  gda_req_if.sink   request,
  gda_rsp_if.source result
);
  import gda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gda_dpath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (request.mode),
    .year_in       (request.year_in),
    .month_in      (request.month_in),
    .day_in        (request.day_in),
    .day_count     (request.day_count),
    .cur_year_out  (result.cur_year_out),
    .cur_month_out (result.cur_month_out),
    .cur_day_out   (result.cur_day_out),
    .order         (result.order),
    .difference    (result.difference),
    .status        (result.status)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the Gregorian date arithmetic block: directed table, then random words.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;

  localparam int MAX_YEAR     = 9999;
  localparam int RANDOM_WORDS = 200;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    mode_t              mode;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [20:0] count;
  } date_word_t;

  typedef struct packed {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    order_t             order;
    logic signed [22:0] diff;
    status_t            status;
  } date_result_t;

  typedef struct packed {
    date_word_t   word;
    logic         typed;
    date_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic steady;   // no idling on either side while set

  gda_req_if request_ch ();
  gda_rsp_if result_ch ();

  gregorian_date_arithmetic #(.MAX_YEAR(MAX_YEAR)) u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow calendar state
  logic [13:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;

  date_result_t pending_dates [$];
  plan_row_t    plan [$];

  int failures;
  int checked;
  int sent;
  int mode_hits [4];
  int invalid_seen;
  int range_seen;
  int idle_cycles;

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint y, longint m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // days from 0001-01-01 to January 1 of year y
  function automatic longint days_before_year(longint y);
    longint p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint date_to_serial(longint y, longint m, longint d);
    longint s;
    s = days_before_year(y);
    for (longint k = 1; k < m && k <= 12; k++) s += month_days(y, k);
    return s + d - 1;
  endfunction

  function automatic bit date_ok(longint y, longint m, longint d);
    if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
    return d <= month_days(y, m);
  endfunction

  function automatic void move_to_serial(longint s);
    longint yy;
    longint mm;
    longint rem;
    yy = (s * 400) / 146097 + 1;
    if (yy < 1) yy = 1;
    while (yy > 1 && days_before_year(yy) > s) yy--;
    while (days_before_year(yy + 1) <= s) yy++;
    rem = s - days_before_year(yy);
    mm = 1;
    while (mm < 12 && rem >= month_days(yy, mm)) begin
      rem -= month_days(yy, mm);
      mm++;
    end
    cal_year  = yy[13:0];
    cal_month = mm[3:0];
    cal_day   = 5'(rem + 1);
  endfunction

  function automatic date_result_t step_calendar(date_word_t w);
    date_result_t r;
    longint s;
    longint delta;
    r = '0;
    r.order  = ORDER_EARLIER;
    r.status = STATUS_OK;
    case (w.mode)
      MODE_LOAD: begin
        if (date_ok(w.year, w.month, w.day)) begin
          cal_year  = w.year;
          cal_month = w.month;
          cal_day   = w.day;
        end else begin
          r.status = STATUS_INVALID;
        end
      end
      MODE_ADD, MODE_SUB: begin
        delta = longint'(w.count);
        s = date_to_serial(cal_year, cal_month, cal_day);
        s += (w.mode == MODE_ADD) ? delta : -delta;
        if (s < 0 || s >= days_before_year(MAX_YEAR + 1)) r.status = STATUS_RANGE;
        else move_to_serial(s);
      end
      default: begin
        if (date_ok(w.year, w.month, w.day)) begin
          s = date_to_serial(cal_year, cal_month, cal_day)
              - date_to_serial(w.year, w.month, w.day);
          r.diff  = 23'(s);
          r.order = (s < 0) ? ORDER_EARLIER : ((s == 0) ? ORDER_EQUAL : ORDER_LATER);
        end else begin
          r.status = STATUS_INVALID;
        end
      end
    endcase
    r.year  = cal_year;
    r.month = cal_month;
    r.day   = cal_day;
    return r;
  endfunction

  function automatic date_word_t make_word(mode_t md, int y, int m, int d, int c);
    date_word_t w;
    w.mode  = md;
    w.year  = 14'(y);
    w.month = 4'(m);
    w.day   = 5'(d);
    w.count = 21'(c);
    return w;
  endfunction

  function automatic plan_row_t checked_row(mode_t md, int y, int m, int d, int c);
    plan_row_t p;
    p = '0;
    p.word = make_word(md, y, m, d, c);
    return p;
  endfunction

  function automatic plan_row_t typed_row(mode_t md, int y, int m, int d, int c,
                                          int ey, int em, int ed, order_t eo, int ediff,
                                          status_t es);
    plan_row_t p;
    p.word         = make_word(md, y, m, d, c);
    p.typed        = 1'b1;
    p.want.year    = 14'(ey);
    p.want.month   = 4'(em);
    p.want.day     = 5'(ed);
    p.want.order   = eo;
    p.want.diff    = 23'(ediff);
    p.want.status  = es;
    return p;
  endfunction

  function automatic date_word_t with_valid_date(date_word_t w);
    int r;
    int y;
    int m;
    r = $urandom_range(0, 99);
    if (r < 70)      y = $urandom_range(1, MAX_YEAR);
    else if (r < 78) y = $urandom_range(1, 3);
    else if (r < 86) y = $urandom_range(MAX_YEAR - 2, MAX_YEAR);
    else             y = $urandom_range(1895, 2105);
    m = $urandom_range(1, 12);
    w.year  = 14'(y);
    w.month = 4'(m);
    w.day   = 5'($urandom_range(1, int'(month_days(y, m))));
    return w;
  endfunction

  function automatic logic signed [20:0] pick_count();
    int r;
    logic signed [20:0] v;
    r = $urandom_range(0, 99);
    if (r < 50)      v = 21'($urandom_range(0, 800));
    else if (r < 80) v = 21'($urandom_range(0, 40000));
    else             return 21'($urandom());
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic send_word(date_word_t w, logic typed, date_result_t want);
    date_result_t guess;
    while (!steady && $urandom_range(0, 99) < 30) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid     <= 1'b1;
    request_ch.mode      <= w.mode;
    request_ch.year_in   <= w.year;
    request_ch.month_in  <= w.month;
    request_ch.day_in    <= w.day;
    request_ch.day_count <= w.count;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    // predictor always advances; typed rows override only the expectation
    guess = step_calendar(w);
    if (typed) guess = want;
    pending_dates.push_back(guess);
    sent++;
    mode_hits[w.mode]++;
    if (guess.status == STATUS_INVALID) invalid_seen++;
    if (guess.status == STATUS_RANGE) range_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else     result_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin : check_results
    date_result_t got;
    date_result_t want;
    logic bad;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.year   = result_ch.cur_year_out;
      got.month  = result_ch.cur_month_out;
      got.day    = result_ch.cur_day_out;
      got.order  = order_t'(result_ch.order);
      got.diff   = result_ch.difference;
      got.status = status_t'(result_ch.status);
      if (pending_dates.size() == 0) begin
        note_failure($sformatf("unexpected result %0d-%0d-%0d", got.year, got.month, got.day));
      end else begin
        want = pending_dates.pop_front();
        checked++;
        bad = (got.year !== want.year) || (got.month !== want.month) ||
              (got.day !== want.day) || (got.order !== want.order) ||
              (got.diff !== want.diff) || (got.status !== want.status);
        if (bad)
          note_failure($sformatf(
            "mismatch: got %0d-%0d-%0d ord %0d diff %0d st %0d, want %0d-%0d-%0d ord %0d diff %0d st %0d",
            got.year, got.month, got.day, got.order, got.diff, got.status,
            want.year, want.month, want.day, want.order, want.diff, want.status));
      end
    end
  end

  // Watchdog: cycles since the last word moved on either channel
  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    date_word_t w;
    int r;
    int md;
    rst                  = 1'b1;
    steady               = 1'b0;
    request_ch.valid     = 1'b0;
    request_ch.mode      = MODE_LOAD;
    request_ch.year_in   = '0;
    request_ch.month_in  = '0;
    request_ch.day_in    = '0;
    request_ch.day_count = '0;
    cal_year             = 14'd2019;
    cal_month            = 4'd1;
    cal_day              = 5'd1;

    // reset date, year extremes, range errors, bad dates, leap rules, count extremes
    plan.push_back(typed_row(MODE_CMP, 2019, 1, 1, 0, 2019, 1, 1, ORDER_EQUAL, 0, STATUS_OK));
    plan.push_back(typed_row(MODE_LOAD, 1, 1, 1, 0, 1, 1, 1, ORDER_EARLIER, 0, STATUS_OK));
    plan.push_back(typed_row(MODE_SUB, 0, 0, 0, 1, 1, 1, 1, ORDER_EARLIER, 0, STATUS_RANGE));
    plan.push_back(typed_row(MODE_ADD, 0, 0, 0, -1, 1, 1, 1, ORDER_EARLIER, 0, STATUS_RANGE));
    plan.push_back(typed_row(MODE_ADD, 0, 0, 0, -1048576, 1, 1, 1, ORDER_EARLIER, 0,
                             STATUS_RANGE));
    plan.push_back(typed_row(MODE_LOAD, 9999, 12, 31, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_OK));
    plan.push_back(typed_row(MODE_ADD, 0, 0, 0, 1, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_RANGE));
    plan.push_back(typed_row(MODE_ADD, 0, 0, 0, 1048575, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_RANGE));
    plan.push_back(typed_row(MODE_LOAD, 0, 1, 1, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_LOAD, 16383, 15, 31, -1, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_LOAD, 2019, 0, 1, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_LOAD, 2019, 13, 1, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_LOAD, 2019, 1, 0, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_LOAD, 2019, 2, 29, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_LOAD, 1900, 2, 29, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_LOAD, 2023, 4, 31, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(typed_row(MODE_CMP, 0, 0, 0, 0, 9999, 12, 31, ORDER_EARLIER, 0,
                             STATUS_INVALID));
    plan.push_back(checked_row(MODE_CMP, 1, 1, 1, 0));
    plan.push_back(typed_row(MODE_LOAD, 2000, 2, 29, 0, 2000, 2, 29, ORDER_EARLIER, 0,
                             STATUS_OK));
    plan.push_back(checked_row(MODE_ADD, 0, 0, 0, 1));
    plan.push_back(checked_row(MODE_SUB, 0, 0, 0, 1));
    plan.push_back(typed_row(MODE_LOAD, 2024, 2, 29, 0, 2024, 2, 29, ORDER_EARLIER, 0,
                             STATUS_OK));
    plan.push_back(checked_row(MODE_SUB, 0, 0, 0, -1048576));
    plan.push_back(checked_row(MODE_CMP, 9999, 12, 31, 0));
    plan.push_back(checked_row(MODE_SUB, 0, 0, 0, 1048575));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 80 && n < 140);
      // don't-care fields get full-width noise
      w = make_word(MODE_LOAD, $urandom_range(0, 16383), $urandom_range(0, 15),
                    $urandom_range(0, 31), int'($urandom()));
      r = $urandom_range(0, 99);
      if (r < 20) begin
        w = with_valid_date(w);
      end else if (r < 35) begin
        w.mode  = MODE_ADD;
        w.count = pick_count();
      end else if (r < 50) begin
        w.mode  = MODE_SUB;
        w.count = pick_count();
      end else if (r < 72) begin
        w = with_valid_date(w);
        w.mode = MODE_CMP;
      end else if (r < 82) begin
        w.mode = mode_t'($urandom_range(0, 3));
      end else begin
        // day past the end of the month, or day zero
        w = with_valid_date(w);
        w.mode = $urandom_range(0, 1) ? MODE_LOAD : MODE_CMP;
        md = int'(month_days(w.year, w.month));
        w.day = (md == 31) ? 5'd0 : 5'($urandom_range(md + 1, 31));
      end
      send_word(w, 1'b0, '0);
    end
    steady = 1'b0;

    request_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d load, %0d add, %0d subtract, %0d compare; %0d results checked.",
             sent, mode_hits[MODE_LOAD], mode_hits[MODE_ADD], mode_hits[MODE_SUB],
             mode_hits[MODE_CMP], checked);
    $display("Results with a bad date: %0d, shifts out of range: %0d.", invalid_seen, range_seen);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
